@@ sv/liu_pkg.sv @@
// Package for the linear index unravel block.
// Holds field widths, pipeline geometry and register indexes; no dependencies.
package liu_pkg;

  localparam int IDX_W   = 31;  // linear index and coordinate zero
  localparam int REM_W   = 11;  // partial remainder, as wide as one extent
  localparam int COORD_W = 10;  // coordinates one to three
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  // Each division takes IDX_W restoring steps, STEPS_PER_STAGE per stage, fewer in the last.
  localparam int STEPS_PER_STAGE = 4;
  localparam int STAGES_PER_DIV  = (IDX_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int NUM_DIVS        = 3;
  localparam int NUM_STAGES      = STAGES_PER_DIV * NUM_DIVS;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3 = 2'd3;

  typedef logic [IDX_W-1:0]   quot_t;
  typedef logic [REM_W-1:0]   rem_t;
  typedef logic [COORD_W-1:0] coord_t;
  // Coordinates finished so far: [0] dimension three, [1] two; [2] stays zero.
  typedef coord_t [NUM_DIVS-1:0] coord_set_t;

endpackage

@@ sv/liu_div_stage.sv @@
// One register stage of the restoring divider chain.
// Performs STEPS quotient-bit steps on the item it takes in; uses liu_pkg.
module liu_div_stage #(
  parameter int STEPS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  liu_pkg::quot_t      q_in,
  input  liu_pkg::rem_t       r_in,
  input  liu_pkg::rem_t       divisor,
  input  liu_pkg::coord_set_t c_in,
  output logic                valid_out,
  output liu_pkg::quot_t      q_out,
  output liu_pkg::rem_t       r_out,
  output liu_pkg::coord_set_t c_out
);
  import liu_pkg::*;

  quot_t q_step;
  rem_t  r_step;

  // Shift one dividend bit into the remainder and subtract when it fits.
  always_comb begin
    logic [REM_W:0] t;
    logic [REM_W:0] diff;
    logic           ge;
    q_step = q_in;
    r_step = r_in;
    for (int i = 0; i < STEPS; i++) begin
      t      = {r_step, q_step[IDX_W-1]};
      diff   = t - {1'b0, divisor};
      ge     = (t >= {1'b0, divisor});
      r_step = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
      q_step = {q_step[IDX_W-2:0], ge};
    end
  end

  // Stage register; holds while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_out <= q_step;
      r_out <= r_step;
      c_out <= c_in;
    end
  end

endmodule

@@ sv/linear_index_unravel.sv @@
// Top level of the linear index unravel block.
// Depends on liu_pkg and liu_div_stage.
//
// Turns a linear chunk or cell number into a row-major coordinate of up to
// four dimensions. The index is divided by the extent of the last dimension
// in use, the quotient by the next extent down, and so on; each remainder
// is one coordinate and the last quotient is coordinate zero.
// Input items arrive on s_tvalid/s_tready/s_tdata, results leave on
// m_tvalid/m_tready/m_tdata. The cfg_we/cfg_index/cfg_data port writes
// num_dims and the extents of dimensions one to three; write it only while
// no item is in flight.
// From acceptance to m_tvalid an item passes three 31-bit divisions,
// each a chain of 8 stages of up to 4 restoring steps. One item is accepted
// every cycle unless the chain holds. When m_tready is low with a result waiting,
// the whole chain holds and s_tready drops; nothing is lost or repeated. Reset
// empties the chain and sets one dimension with all extents one.
module linear_index_unravel #(
  parameter int MAX_DIMS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] linear_index, [31] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [30:0] coord_0, [40:31] coord_1,
                                 // [50:41] coord_2, [60:51] coord_3
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import liu_pkg::*;

  localparam int LIM = (MAX_DIMS < 4) ? MAX_DIMS : 4;

  logic [2:0] num_dims;
  rem_t       size1, size2, size3;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= 3'd1;
      size1    <= rem_t'(1);
      size2    <= rem_t'(1);
      size3    <= rem_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_DIMS:  num_dims <= cfg_data[2:0];
        REG_SIZE_DIM1: size1    <= cfg_data;
        REG_SIZE_DIM2: size2    <= cfg_data;
        REG_SIZE_DIM3: size3    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions in use, and the divisor of each division; an unused one
  // divides by one so its coordinate comes out zero.
  logic [2:0] nd, n_use;
  rem_t       div_sel [NUM_DIVS];
  always_comb begin
    nd    = (num_dims == 3'd0) ? 3'd1 : num_dims;
    n_use = (nd > 3'(LIM)) ? 3'(LIM) : nd;
    div_sel[0] = (n_use >= 3'd4 && size3 != '0) ? size3 : rem_t'(1);
    div_sel[1] = (n_use >= 3'd3 && size2 != '0) ? size2 : rem_t'(1);
    div_sel[2] = (n_use >= 3'd2 && size1 != '0) ? size1 : rem_t'(1);
  end

  logic       adv;
  logic       vld [NUM_STAGES+1];
  quot_t      q   [NUM_STAGES+1];
  rem_t       r   [NUM_STAGES+1];
  coord_set_t c   [NUM_STAGES+1];

  // The chain moves whenever the output register is empty or being taken.
  assign adv      = m_tready || !vld[NUM_STAGES];
  assign s_tready = adv;

  assign vld[0] = s_tvalid;
  assign q[0]   = s_tdata[IDX_W-1:0];
  assign r[0]   = '0;
  assign c[0]   = '0;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int D  = s / STAGES_PER_DIV;
    localparam int J  = s % STAGES_PER_DIV;
    localparam int NS = (IDX_W - J * STEPS_PER_STAGE < STEPS_PER_STAGE) ?
                        (IDX_W - J * STEPS_PER_STAGE) : STEPS_PER_STAGE;
    rem_t       r_in;
    coord_set_t c_in;

    // At the start of a division, bank the previous remainder as a coordinate.
    always_comb begin
      c_in = c[s];
      r_in = r[s];
      if (J == 0) begin
        r_in = '0;
        if (D > 0) begin
          c_in[(D > 0) ? D - 1 : 0] = r[s][COORD_W-1:0];
        end
      end
    end

    liu_div_stage #(.STEPS(NS)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .valid_in  (vld[s]),
      .q_in      (q[s]),
      .r_in      (r_in),
      .divisor   (div_sel[D]),
      .c_in      (c_in),
      .valid_out (vld[s+1]),
      .q_out     (q[s+1]),
      .r_out     (r[s+1]),
      .c_out     (c[s+1])
    );
  end

  // Output item: the last remainder is coordinate one.
  assign m_tvalid = vld[NUM_STAGES];
  assign m_tdata  = {3'b000, c[NUM_STAGES][0], c[NUM_STAGES][1],
                     r[NUM_STAGES][COORD_W-1:0], q[NUM_STAGES]};

endmodule

@@ tb/sv/linear_index_unravel_test.sv @@
// Testbench for the linear index unravel block: directed table, then random items.
// Depends on liu_pkg and linear_index_unravel; predicts coordinate sets itself where the table gives none.
module linear_index_unravel_test;
  import liu_pkg::*;

  localparam int LATENCY = 24;
  localparam int LIMIT_CYCLES = 600000;
  localparam int NUM_RANDOM = 1450;

  typedef struct packed {
    logic [30:0] c0;
    logic [9:0]  c1;
    logic [9:0]  c2;
    logic [9:0]  c3;
  } coords_t;

  typedef struct {
    logic [30:0] idx;
    bit          known;
    coords_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_NUM_DIMS;
  logic [10:0] cfg_data = '0;

  // Shadow configuration used by the predictor.
  logic [2:0]  dims_reg;
  logic [10:0] extent_reg [1:3];

  coords_t pending_coords [$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_recv = 1'b0;

  linear_index_unravel u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // Row-major unravel with the block's saturation and wrapping rules.
  function automatic coords_t unravel(input logic [30:0] idx);
    longint unsigned rem, div, e;
    longint unsigned c [4];
    int n;
    coords_t r;
    n = dims_reg;
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    c = '{0, 0, 0, 0};
    rem = idx;
    for (int k = 0; k + 1 < n; k++) begin
      div = 1;
      for (int j = k + 1; j < n; j++) begin
        e = extent_reg[j];
        div *= (e == 0) ? 1 : e;
      end
      c[k] = rem / div;
      rem = rem % div;
    end
    c[n-1] = rem;
    r.c0 = c[0][30:0];
    r.c1 = c[1][9:0];
    r.c2 = c[2][9:0];
    r.c3 = c[3][9:0];
    return r;
  endfunction

  // Receiver: random stalls, long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: compare each result with the oldest expectation.
  always @(posedge clk) begin
    coords_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.c0 = m_tdata[30:0];
      got.c1 = m_tdata[40:31];
      got.c2 = m_tdata[50:41];
      got.c3 = m_tdata[60:51];
      if (pending_coords.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want = pending_coords.pop_front();
        if (got.c0 !== want.c0) report_mismatch("coord_0", 64'(got.c0), 64'(want.c0));
        if (got.c1 !== want.c1) report_mismatch("coord_1", 64'(got.c1), 64'(want.c1));
        if (got.c2 !== want.c2) report_mismatch("coord_2", 64'(got.c2), 64'(want.c2));
        if (got.c3 !== want.c3) report_mismatch("coord_3", 64'(got.c3), 64'(want.c3));
      end
    end
  end

  // Offer one item and wait for its acceptance; the expectation is queued then.
  // The valid stays up after acceptance so items can follow back to back.
  task automatic send_index(input logic [30:0] idx, input bit known, input coords_t want);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) s_tvalid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_coords.push_back(known ? want : unravel(idx));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Register write while idle; the shadow follows.
  task automatic write_reg(input logic [1:0] index, input logic [10:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    if (index == REG_NUM_DIMS) dims_reg = value[2:0];
    else extent_reg[index] = value;
  endtask

  task automatic set_shape(input logic [10:0] nd, input logic [10:0] e1,
                           input logic [10:0] e2, input logic [10:0] e3);
    write_reg(REG_NUM_DIMS, nd);
    write_reg(REG_SIZE_DIM1, e1);
    write_reg(REG_SIZE_DIM2, e2);
    write_reg(REG_SIZE_DIM3, e3);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [30:0] rand_index();
    case ($urandom_range(3))
      0: return 31'($urandom_range(4095));
      1: return 31'($urandom);
      2: return 31'h7FFF_FFFF - 31'($urandom_range(255));
      default: return 31'($urandom_range(1 << 20));
    endcase
  endfunction

  function automatic logic [10:0] rand_extent();
    case ($urandom_range(5))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'($urandom_range(2047, 1025));
      default: return 11'($urandom_range(1, 64));
    endcase
  endfunction

  // Long receiver hold-off, counted in its own process.
  task automatic hold_receiver(input int cycles);
    hold_recv = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_recv = 1'b0;
  endtask

  initial begin
    row_t directed [$];
    coords_t z;
    int phase;
    z = '0;
    dims_reg = 3'd1;
    extent_reg[1] = 11'd1;
    extent_reg[2] = 11'd1;
    extent_reg[3] = 11'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset: one dimension, coord_0 is the index itself.
    directed = '{
      '{31'd0, 1'b1, '{31'd0, 10'd0, 10'd0, 10'd0}},
      '{31'h7FFF_FFFF, 1'b1, '{31'h7FFF_FFFF, 10'd0, 10'd0, 10'd0}},
      '{31'h5555_5555, 1'b1, '{31'h5555_5555, 10'd0, 10'd0, 10'd0}},
      '{31'h2AAA_AAAA, 1'b1, '{31'h2AAA_AAAA, 10'd0, 10'd0, 10'd0}}
    };
    foreach (directed[i]) send_index(directed[i].idx, directed[i].known, directed[i].want);
    drain();

    // Zero dimensions act as one.
    set_shape(11'd0, 11'd7, 11'd7, 11'd7);
    send_index(31'd12345, 1'b1, '{31'd12345, 10'd0, 10'd0, 10'd0});
    drain();

    // Four dimensions of 1024: index splits into 10-bit fields.
    set_shape(11'd4, 11'd1024, 11'd1024, 11'd1024);
    directed = '{
      '{31'h7FFF_FFFF, 1'b1, '{31'd1, 10'h3FF, 10'h3FF, 10'h3FF}},
      '{31'd0, 1'b1, '{31'd0, 10'd0, 10'd0, 10'd0}},
      '{31'd1023, 1'b1, '{31'd0, 10'd0, 10'd0, 10'd1023}},
      '{31'd1024, 1'b1, '{31'd0, 10'd0, 10'd1, 10'd0}}
    };
    foreach (directed[i]) send_index(directed[i].idx, directed[i].known, directed[i].want);
    drain();

    // Too many dimensions saturate; zero extents act as one.
    set_shape(11'd7, 11'd0, 11'd0, 11'd0);
    send_index(31'd99, 1'b1, '{31'd99, 10'd0, 10'd0, 10'd0});
    drain();

    // Extents above range: wrapped coordinates.
    set_shape(11'd2, 11'd2047, 11'd1, 11'd1);
    for (int i = 0; i < 4; i++) send_index(31'd2046 - 31'(i), 1'b0, z);
    send_index(31'h7FFF_FFFF, 1'b0, z);
    drain();
    set_shape(11'd3, 11'd1025, 11'd2047, 11'd5);
    for (int i = 0; i < 4; i++) send_index(rand_index(), 1'b0, z);
    drain();

    // Random phases with different idling and shapes.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      set_shape(11'($urandom_range(7)), rand_extent(), rand_extent(), rand_extent());
      if (phase == 4) begin
        fork
          hold_receiver(200);
        join_none
      end
      for (int i = 0; i < NUM_RANDOM / 8; i++) send_index(rand_index(), 1'b0, z);
      // Sender pauses until every expected result has come.
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/liu_pkg.sv
sv/liu_div_stage.sv
sv/linear_index_unravel.sv
tb/sv/linear_index_unravel_test.sv
